// ----- hw/rtl/tdm_pkg.sv -----
// Shared types, codes, constants and table builder for the tanh drive mixer.
`timescale 1ns / 1ps

package tdm_pkg;

    localparam int TANH_SEGMENTS_DEF = 256;
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int OUT_DEPTH_DEF     = 16;
    localparam int MID_DEPTH         = 4;
    localparam int LANE_LAT          = 7;

    localparam logic [15:0] FULL_SCALE = 16'd32768;

    localparam logic [1:0] MODE_ABS = 2'd1;
    localparam logic [1:0] MODE_REL = 2'd2;

    localparam logic [2:0] REG_BASE_DRIVE  = 3'd0;
    localparam logic [2:0] REG_BASE_MIX    = 3'd1;
    localparam logic [2:0] REG_DRIVE_MODE  = 3'd2;
    localparam logic [2:0] REG_MIX_MODE    = 3'd3;
    localparam logic [2:0] REG_RAMP_STEPS  = 3'd4;
    localparam logic [2:0] REG_RAMP_RECIP  = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD
    } t_state;

    typedef struct packed {
        logic [15:0] base_drive;
        logic [15:0] base_mix;
        logic [1:0]  drive_mode;
        logic [1:0]  mix_mode;
        logic [15:0] ramp_steps;
        logic [24:0] ramp_recip;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic commit;
    } t_sm_ctl;

    // Map base register and control voltage to a 0..full-scale target.
    function automatic logic [15:0] form_target(input logic [15:0] base,
                                                input logic [1:0]  mode,
                                                input logic [15:0] cv);
        logic signed [17:0] t;
        logic [15:0]        r;
        t = $signed({2'b00, base}) + $signed({2'b00, cv}) - 18'sd32768;
        unique case (mode)
            MODE_ABS: r = {1'b0, cv[15:1]};
            MODE_REL: begin
                if (t < 18'sd0) begin
                    r = 16'd0;
                end else if (t > 18'sd32768) begin
                    r = FULL_SCALE;
                end else begin
                    r = t[15:0];
                end
            end
            default:  r = (base > FULL_SCALE) ? FULL_SCALE : base;
        endcase
        return r;
    endfunction

    // Shift-subtract quotient, evaluated at elaboration only.
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], a[k]};
            if (r >= b) begin
                r    = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry idx of the tanh curve over [0, 8], scaled to the sample range.
    function automatic logic [31:0] tanh_entry(input int seg, input int sb, input int idx);
        logic [63:0] one;
        logic [63:0] term;
        logic [63:0] c;
        logic [63:0] q;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] t;
        logic [63:0] smax;
        one  = 64'd1 << 31;
        term = one;
        c    = one;
        q    = one;
        smax = (64'd1 << (sb - 1)) - 64'd1;
        for (int n = 1; n <= 30; n++) begin
            term = udiv(term * 64'd16, 64'(seg) * 64'(n));
            if ((n % 2) == 1) begin
                c = c - term;
            end else begin
                c = c + term;
            end
        end
        for (int i = 0; i < idx; i++) begin
            q = (q * c + (64'd1 << 30)) >> 31;
        end
        den = one + q;
        num = ((one - q) << (sb - 1)) + (den >> 1);
        t   = udiv(num, den);
        if (t > smax) begin
            t = smax;
        end
        return t[31:0];
    endfunction

endpackage

// ----- hw/rtl/tdm_queue.sv -----
// Small register FIFO with first-word fall-through read.
`timescale 1ns / 1ps

module tdm_queue
    import tdm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_comb begin
        n_wp  = w_wr ? ((r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp  = w_rd ? ((r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt + CW'(w_wr) - CW'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a write");
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= AW'(DEPTH - 1)) else $error("write pointer out of range");
endmodule

// ----- hw/rtl/tdm_smooth.sv -----
// Linear ramp smoother for one control target.
`timescale 1ns / 1ps

module tdm_smooth
    import tdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sm_ctl     i_ctl,
    input  logic [15:0] i_target,
    input  logic [15:0] i_steps,
    input  logic [24:0] i_recip,
    output logic [15:0] o_value
);
    logic [15:0]        r_targ;
    logic signed [59:0] r_prod;
    logic [31:0]        r_now, n_now;
    logic [15:0]        r_goal, n_goal;
    logic signed [31:0] r_inc, n_inc;
    logic [15:0]        r_cnt, n_cnt;

    logic signed [33:0] w_diff;
    logic signed [35:0] w_step;
    logic               w_chg;
    logic [31:0]        w_now1;
    logic signed [31:0] w_inc1;
    logic [15:0]        w_cnt1;
    logic signed [33:0] w_sum;

    assign w_diff = $signed({2'b00, r_targ, 16'd0}) - $signed({2'b00, r_now});
    assign w_step = 36'(r_prod >>> 24);
    assign w_chg  = (r_targ != r_goal);

    always_comb begin
        w_now1 = r_now;
        w_inc1 = r_inc;
        w_cnt1 = r_cnt;
        n_goal = r_goal;
        if (w_chg) begin
            n_goal = r_targ;
            if (i_steps == '0) begin
                w_now1 = {r_targ, 16'd0};
                w_cnt1 = '0;
            end else begin
                w_cnt1 = i_steps;
                if (w_step > 36'sh0_7FFF_FFFF) begin
                    w_inc1 = 32'sh7FFF_FFFF;
                end else if (w_step < -36'sh0_8000_0000) begin
                    w_inc1 = -32'sh8000_0000;
                end else begin
                    w_inc1 = w_step[31:0];
                end
            end
        end
        w_sum  = $signed({2'b00, w_now1}) + 34'(w_inc1);
        n_inc  = w_inc1;
        n_now  = w_now1;
        n_cnt  = w_cnt1;
        o_value = n_goal;
        if (w_cnt1 != '0) begin
            n_cnt = w_cnt1 - 1'b1;
            if (n_cnt != '0) begin
                if (w_sum < 34'sd0) begin
                    n_now = '0;
                end else if (w_sum > 34'sh0_8000_0000) begin
                    n_now = 32'h8000_0000;
                end else begin
                    n_now = w_sum[31:0];
                end
            end else begin
                n_now = {n_goal, 16'd0};
            end
            o_value = n_now[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_targ <= i_target;
        end
        r_prod <= 60'(w_diff * $signed({1'b0, i_recip}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_goal <= '0;
            r_inc  <= '0;
            r_cnt  <= '0;
        end else if (i_ctl.commit) begin
            r_now  <= n_now;
            r_goal <= n_goal;
            r_inc  <= n_inc;
            r_cnt  <= n_cnt;
        end
    end

    a_now_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_now <= 32'h8000_0000) else $error("smoothed value beyond full scale");
    a_zero_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && !w_chg && r_cnt == '0) |=> $stable(r_now))
        else $error("idle smoother moved");
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |-> (o_value <= FULL_SCALE)) else $error("control value too large");
endmodule

// ----- hw/rtl/tdm_front.sv -----
// Front end: takes frames, forms targets and runs both smoothers.
`timescale 1ns / 1ps

module tdm_front
    import tdm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [SAMPLE_BITS-1:0] i_left,
    input  logic [SAMPLE_BITS-1:0] i_right,
    input  logic [15:0]            i_dcv,
    input  logic [15:0]            i_mcv,
    output logic                   o_wr,
    input  logic                   i_qfull,
    output logic [SAMPLE_BITS-1:0] o_left,
    output logic [SAMPLE_BITS-1:0] o_right,
    output logic [15:0]            o_drive,
    output logic [15:0]            o_mix
);
    t_state  r_state, n_state;
    t_sm_ctl w_ctl;
    logic [SAMPLE_BITS-1:0] r_left, r_right;

    always_comb begin
        n_state      = r_state;
        w_ctl.load   = 1'b0;
        w_ctl.commit = 1'b0;
        o_full       = 1'b1;
        o_wr         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    w_ctl.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: n_state = S_UPD;
            S_UPD: begin
                // hold the frame until the queue has room
                if (!i_qfull) begin
                    o_wr         = 1'b1;
                    w_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_left  <= i_left;
            r_right <= i_right;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

    tdm_smooth u_drive (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_target (form_target(i_cfg.base_drive, i_cfg.drive_mode, i_dcv)),
        .i_steps  (i_cfg.ramp_steps),
        .i_recip  (i_cfg.ramp_recip),
        .o_value  (o_drive)
    );

    tdm_smooth u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_target (form_target(i_cfg.base_mix, i_cfg.mix_mode, i_mcv)),
        .i_steps  (i_cfg.ramp_steps),
        .i_recip  (i_cfg.ramp_recip),
        .o_value  (o_mix)
    );

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr |=> !o_wr) else $error("front wrote twice for one frame");
    a_load_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |=> (r_state == S_MUL)) else $error("front skipped multiply step");
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_full) else $error("front open while busy");
endmodule

// ----- hw/rtl/tdm_lane.sv -----
// One channel: tanh shaping by table interpolation and dry/wet blend.
`timescale 1ns / 1ps

module tdm_lane
    import tdm_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int TANH_SEGMENTS = TANH_SEGMENTS_DEF
) (
    input  logic                          i_clk,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic [15:0]                   i_drive,
    input  logic [15:0]                   i_mix,
    output logic [SAMPLE_BITS-1:0]        o_y
);
    localparam int SB   = SAMPLE_BITS;
    localparam int SEG  = TANH_SEGMENTS;
    localparam int GAIN = 5 * SEG;
    localparam int GW   = $clog2(GAIN + 1);
    localparam int IW   = $clog2(SEG + 1);
    localparam int PW   = SB + 16 + GW;
    localparam logic signed [SB+19:0] SMAX = (SB+20)'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [SB+19:0] SMIN = -SMAX - 1'b1;

    logic [SB-1:0] w_curve [SEG+1];

    for (genvar g = 0; g <= SEG; g++) begin : g_curve
        localparam logic [31:0] ENTRY = tanh_entry(SEG, SB, g);
        assign w_curve[g] = ENTRY[SB-1:0];
    end

    logic signed [SB:0]    w_negx;
    logic [SB-1:0]         w_mag;
    logic [GW-1:0]         w_idx;
    logic [IW-1:0]         w_ilo;
    logic                  w_sat;
    logic signed [SB+17:0] w_y;
    logic signed [SB+1:0]  w_y2;
    logic signed [SB+19:0] w_sum;
    logic signed [SB+19:0] w_r;

    logic signed [SB-1:0]  r1_x, r2_x, r3_x, r4_x, r5_x;
    logic [15:0]           r1_mix, r2_mix, r3_mix, r4_mix, r5_mix;
    logic                  r1_neg, r2_neg, r3_neg, r4_neg;
    logic [SB+15:0]        r1_m;
    logic [PW-1:0]         r2_p;
    logic [SB-1:0]         r3_c0, r4_c0;
    logic signed [SB:0]    r3_dif;
    logic [15:0]           r3_frac;
    logic signed [SB+17:0] r4_pr;
    logic signed [SB+1:0]  r5_wet;
    logic signed [SB+17:0] r6_dry;
    logic signed [SB+18:0] r6_wm;
    logic [SB-1:0]         r7_y;

    assign w_negx = -$signed({i_x[SB-1], i_x});
    assign w_mag  = i_x[SB-1] ? w_negx[SB-1:0] : i_x;
    assign w_idx  = r2_p[PW-1:SB+16];
    assign w_ilo  = w_idx[IW-1:0];
    assign w_sat  = (w_idx >= GW'(SEG));
    assign w_y    = $signed({18'd0, r4_c0}) + (r4_pr >>> 16);
    assign w_y2   = w_y[SB+1:0];
    assign w_sum  = (SB+20)'(r6_dry) + (SB+20)'(r6_wm) + (SB+20)'(16384);
    assign w_r    = w_sum >>> 15;

    always_ff @(posedge i_clk) begin
        r1_x   <= i_x;
        r1_mix <= i_mix;
        r1_neg <= i_x[SB-1];
        r1_m   <= w_mag * i_drive;

        r2_x   <= r1_x;
        r2_mix <= r1_mix;
        r2_neg <= r1_neg;
        r2_p   <= PW'(r1_m * GW'(GAIN));

        r3_x    <= r2_x;
        r3_mix  <= r2_mix;
        r3_neg  <= r2_neg;
        r3_frac <= r2_p[SB+15:SB];
        if (w_sat) begin
            r3_c0  <= w_curve[SEG];
            r3_dif <= '0;
        end else begin
            r3_c0  <= w_curve[w_ilo];
            r3_dif <= $signed({1'b0, w_curve[IW'(w_ilo + 1'b1)]})
                      - $signed({1'b0, w_curve[w_ilo]});
        end

        r4_x   <= r3_x;
        r4_mix <= r3_mix;
        r4_neg <= r3_neg;
        r4_c0  <= r3_c0;
        r4_pr  <= (SB+18)'(r3_dif * $signed({1'b0, r3_frac}));

        r5_x   <= r4_x;
        r5_mix <= r4_mix;
        r5_wet <= r4_neg ? -w_y2 : w_y2;

        r6_dry <= (SB+18)'($signed({1'b0, 17'd32768 - {1'b0, r5_mix}}) * r5_x);
        r6_wm  <= (SB+19)'($signed({1'b0, r5_mix}) * r5_wet);

        if (w_r > SMAX) begin
            r7_y <= SMAX[SB-1:0];
        end else if (w_r < SMIN) begin
            r7_y <= SMIN[SB-1:0];
        end else begin
            r7_y <= w_r[SB-1:0];
        end
    end

    assign o_y = r7_y;
endmodule

// ----- hw/rtl/tdm_back.sv -----
// Back end: issues frames into both channel pipelines against output room.
`timescale 1ns / 1ps

module tdm_back
    import tdm_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int TANH_SEGMENTS = TANH_SEGMENTS_DEF,
    parameter int OUT_DEPTH     = OUT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_avail,
    output logic                           o_take,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_room,
    input  logic [SAMPLE_BITS-1:0]         i_left,
    input  logic [SAMPLE_BITS-1:0]         i_right,
    input  logic [15:0]                    i_drive,
    input  logic [15:0]                    i_mix,
    output logic                           o_valid,
    output logic [SAMPLE_BITS-1:0]         o_left,
    output logic [SAMPLE_BITS-1:0]         o_right
);
    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int LW = $clog2(LANE_LAT + 2);
    localparam int MW = (CW > LW) ? CW : LW;

    logic [LANE_LAT-1:0] r_vld;
    logic [LW-1:0]       w_flight;

    // words in flight plus this one must fit in the output queue
    assign w_flight = LW'($countones(r_vld));
    assign o_take   = i_avail && ((MW'(w_flight) + 1'b1) <= MW'(i_room));
    assign o_valid  = r_vld[LANE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_LAT-2:0], o_take};
        end
    end

    tdm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .TANH_SEGMENTS(TANH_SEGMENTS)) u_left (
        .i_clk   (i_clk),
        .i_x     ($signed(i_left)),
        .i_drive (i_drive),
        .i_mix   (i_mix),
        .o_y     (o_left)
    );

    tdm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .TANH_SEGMENTS(TANH_SEGMENTS)) u_right (
        .i_clk   (i_clk),
        .i_x     ($signed(i_right)),
        .i_drive (i_drive),
        .i_mix   (i_mix),
        .o_y     (o_right)
    );

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (i_room != '0)) else $error("result word with no queue room");
    a_issue_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> ##(LANE_LAT) o_valid) else $error("issued word lost in pipeline");
    a_take_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> i_avail) else $error("issue from empty queue");
endmodule

// ----- hw/rtl/tanh_drive_dry_wet_mixer.sv -----
// Top level of the stereo tanh drive saturator with dry/wet blend.
//
//   channel   handshake                      payload
//   -------   ---------------------------    -------------------------------------
//   input     i_push / o_full                i_sample_left/right, i_drive/mix_voltage
//   result    o_empty / i_pop                o_out_left, o_out_right
//   config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// The front end takes a frame in steps: target forming, the ramp step multiply, then the
// smoother update, which waits for room in the middle queue before the next frame is taken.
// Reset is synchronous; it clears smoothers, queues and pipeline valid bits.
// A stalled result side fills the output queue, then the middle queue, then raises o_full.
// Configuration writes are always ready; each frame step reads the current registers.
`timescale 1ns / 1ps

module tanh_drive_dry_wet_mixer
    import tdm_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int TANH_SEGMENTS = TANH_SEGMENTS_DEF,
    parameter int OUT_DEPTH     = OUT_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [SAMPLE_BITS-1:0] i_sample_left,
    input  logic [SAMPLE_BITS-1:0] i_sample_right,
    input  logic [15:0]            i_drive_voltage,
    input  logic [15:0]            i_mix_voltage,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [SAMPLE_BITS-1:0] o_out_left,
    output logic [SAMPLE_BITS-1:0] o_out_right,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [24:0]            i_cfg_data
);
    localparam int SB = SAMPLE_BITS;
    localparam int MWD = 2 * SB + 32;
    localparam int CW = $clog2(OUT_DEPTH + 1);

    t_cfg r_cfg;

    logic                  w_mid_wr, w_mid_full, w_mid_empty, w_take;
    logic [MWD-1:0]        w_mid_in, w_mid_out;
    logic [SB-1:0]         w_f_left, w_f_right;
    logic [15:0]           w_f_drive, w_f_mix;
    logic                  w_out_wr, w_out_full;
    logic [SB-1:0]         w_b_left, w_b_right;
    logic [2*SB-1:0]       w_out_data;
    logic [CW-1:0]         w_out_cnt;
    logic [CW-1:0]         w_room;
    logic [$clog2(MID_DEPTH+1)-1:0] w_mid_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_drive <= 16'd0;
            r_cfg.base_mix   <= 16'd16384;
            r_cfg.drive_mode <= 2'd0;
            r_cfg.mix_mode   <= 2'd0;
            r_cfg.ramp_steps <= 16'd480;
            r_cfg.ramp_recip <= 25'd34953;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_DRIVE: r_cfg.base_drive <= i_cfg_data[15:0];
                REG_BASE_MIX:   r_cfg.base_mix   <= i_cfg_data[15:0];
                REG_DRIVE_MODE: r_cfg.drive_mode <= i_cfg_data[1:0];
                REG_MIX_MODE:   r_cfg.mix_mode   <= i_cfg_data[1:0];
                REG_RAMP_STEPS: r_cfg.ramp_steps <= i_cfg_data[15:0];
                REG_RAMP_RECIP: r_cfg.ramp_recip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tdm_front #(.SAMPLE_BITS(SB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_left  (i_sample_left),
        .i_right (i_sample_right),
        .i_dcv   (i_drive_voltage),
        .i_mcv   (i_mix_voltage),
        .o_wr    (w_mid_wr),
        .i_qfull (w_mid_full),
        .o_left  (w_f_left),
        .o_right (w_f_right),
        .o_drive (w_f_drive),
        .o_mix   (w_f_mix)
    );

    assign w_mid_in = {w_f_left, w_f_right, w_f_drive, w_f_mix};

    tdm_queue #(.WIDTH(MWD), .DEPTH(MID_DEPTH)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_mid_wr),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_rd    (w_take),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty),
        .o_count (w_mid_cnt)
    );

    assign w_room = CW'(OUT_DEPTH) - w_out_cnt;

    tdm_back #(
        .SAMPLE_BITS   (SB),
        .TANH_SEGMENTS (TANH_SEGMENTS),
        .OUT_DEPTH     (OUT_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!w_mid_empty),
        .o_take  (w_take),
        .i_room  (w_room),
        .i_left  (w_mid_out[MWD-1:SB+32]),
        .i_right (w_mid_out[SB+31:32]),
        .i_drive (w_mid_out[31:16]),
        .i_mix   (w_mid_out[15:0]),
        .o_valid (w_out_wr),
        .o_left  (w_b_left),
        .o_right (w_b_right)
    );

    tdm_queue #(.WIDTH(2 * SB), .DEPTH(OUT_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_out_wr),
        .i_data  ({w_b_left, w_b_right}),
        .o_full  (w_out_full),
        .i_rd    (i_pop),
        .o_data  (w_out_data),
        .o_empty (o_empty),
        .o_count (w_out_cnt)
    );

    assign o_out_left  = w_out_data[2*SB-1:SB];
    assign o_out_right = w_out_data[SB-1:0];

    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mid_wr && w_mid_full)) else $error("middle queue overflow");
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_out_wr && w_out_full)) else $error("output queue overflow");
    a_mid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_cnt <= ($clog2(MID_DEPTH+1))'(MID_DEPTH)) else $error("middle queue count");
endmodule
